// ===== hdl/md5_stream_hash_macros.svh =====
// Assertion macros for the MD5 stream hash checker.
`ifndef MD5_STREAM_HASH_MACROS_SVH
`define MD5_STREAM_HASH_MACROS_SVH

// Condition must never hold while out of reset.
`define MD5_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("md5 check failed: never");

// Same-cycle implication.
`define MD5_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5 check failed: imply");

// Next-cycle implication.
`define MD5_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5 check failed: next");

`endif

// ===== hdl/md5_pkg.sv =====
// Types, constant tables and round functions of the MD5 stream hash.
package md5_pkg;

    typedef logic [31:0]      word_t;
    typedef logic [3:0][31:0] chain_t;

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic       load;    // copy chain into working regs, prefetch round 0
        logic       round;   // run one round
        logic       finish;  // fold working regs into chain
        logic       init;    // restore initial chain
        logic [5:0] rnd;     // current round number
    } md5_ctl_t;

    localparam chain_t CHAIN_INIT = {32'h10325476, 32'h98badcfe,
                                     32'hefcdab89, 32'h67452301};

    localparam logic [5:0] POS_LAST   = 6'h3f;
    localparam logic [5:0] POS_LENGTH = 6'd56;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [2:0] MAX_BYTES  = 3'd4;

    localparam word_t ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROUND_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word used by round r.
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] r4;
        r4 = r[3:0];
        case (r[5:4])
            2'd0:    return r4;
            2'd1:    return 4'(r4 * 4'd5 + 4'd1);
            2'd2:    return 4'(r4 * 4'd3 + 4'd5);
            default: return 4'(r4 * 4'd7);
        endcase
    endfunction

    function automatic word_t mix_f(input logic [1:0] grp, input word_t b,
                                    input word_t c, input word_t d);
        case (grp)
            2'd0:    return (b & c) | (~b & d);
            2'd1:    return (b & d) | (c & ~d);
            2'd2:    return b ^ c ^ d;
            default: return c ^ (b | ~d);
        endcase
    endfunction

    function automatic word_t rotl(input word_t v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

endpackage

// ===== hdl/md5_buf.sv =====
// Sixteen-word block buffer with byte-lane writes and one registered read port.
module md5_buf (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [5:0]    wr_pos,
    input  logic [7:0]    wr_byte,
    input  logic [3:0]    rd_idx,
    output md5_pkg::word_t rd_word
);
    import md5_pkg::*;

    word_t store_reg [16];
    word_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
        end
        rd_reg <= store_reg[rd_idx];
    end

    assign rd_word = rd_reg;

endmodule

// ===== hdl/md5_core.sv =====
// MD5 round unit: chaining value, working registers, one round per cycle.
module md5_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  md5_pkg::md5_ctl_t ctl,
    input  md5_pkg::word_t    msg_word,
    output logic [3:0]        msg_idx,
    output md5_pkg::chain_t   chain
);
    import md5_pkg::*;

    chain_t chain_reg, chain_next;
    word_t  a_reg, b_reg, c_reg, d_reg;
    word_t  km_reg;          // K[r] + M[g(r)], registered ahead of round r
    logic [5:0] fetch_rnd;   // round whose message word is read now
    logic [5:0] km_rnd;      // round whose K + M sum is formed now
    word_t  f_val, t_val, b_new;
    logic [4:0] shamt;

    // buffer read is registered: a word arrives in the cycle after its index,
    // so the index runs two rounds ahead of the round being computed
    assign fetch_rnd = ctl.round ? 6'(ctl.rnd + 6'd2) :
                       (ctl.load ? 6'(ctl.rnd + 6'd1) : 6'd0);
    assign km_rnd    = ctl.load ? ctl.rnd : 6'(ctl.rnd + 6'd1);
    assign msg_idx   = msg_index(fetch_rnd);

    assign f_val = mix_f(ctl.rnd[5:4], b_reg, c_reg, d_reg);
    assign t_val = a_reg + f_val + km_reg;
    assign shamt = ROUND_S[{ctl.rnd[5:4], ctl.rnd[1:0]}];
    assign b_new = b_reg + rotl(t_val, shamt);

    always_comb begin
        chain_next = chain_reg;
        if (ctl.init) begin
            chain_next = CHAIN_INIT;
        end else if (ctl.finish) begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= CHAIN_INIT;
        end else begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end else if (ctl.round) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_new;
        end
        if (ctl.load || ctl.round) begin
            km_reg <= ROUND_K[km_rnd] + msg_word;
        end
    end

    assign chain = chain_reg;

endmodule

// ===== hdl/md5_stream_hash.sv =====
// Top level of the MD5 stream hash: byte sequencer, padding and digest output.
//
// MD5 digest over a stream of words. Each input word carries up to four
// message bytes (first byte in bits 7:0), byte_count says how many are valid
// (5 to 7 count as 4), and end_of_message closes the message. After the
// closing word the block returns four digest words A, B, C, D in order,
// word_index 0 to 3, last_word set on D, then starts a fresh message.
// Timing: the block handles one word at a time and s_ready is low while it
// works. Message bytes go into the block buffer one byte per cycle while no
// compression runs. Every time the 64-byte buffer fills, the round unit runs
// the compression (one load, 64 rounds at one per cycle, one chain update).
// On the closing word the padding is written byte by byte (9 to 72 bytes,
// one per cycle) with one or two compressions, and the four digest words
// then leave through the output port, one per cycle while m_ready is high.
// The next message word is taken once D has been accepted.
module md5_stream_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [1:0]  m_word_index,
    output logic        m_last_word
);
    import md5_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BYTES = 3'd1;   // write message bytes
    localparam logic [2:0] ST_PAD   = 3'd2;   // write padding and length
    localparam logic [2:0] ST_LOAD  = 3'd3;   // start compression
    localparam logic [2:0] ST_ROUND = 3'd4;   // 64 rounds
    localparam logic [2:0] ST_ADD   = 3'd5;   // chain update
    localparam logic [2:0] ST_OUT   = 3'd6;   // deliver digest words

    logic [2:0]  state_reg, state_next;
    logic [31:0] data_reg, data_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        eom_reg, eom_next;
    logic [2:0]  bidx_reg, bidx_next;     // byte index within the word
    logic [5:0]  pos_reg, pos_next;       // fill position in the block
    logic [63:0] len_reg, len_next;       // message bit count
    logic        pad_reg, pad_next;       // padding in progress
    logic        first_reg, first_next;   // next pad byte is the 0x80 mark
    logic        tail_reg, tail_next;     // writing the length bytes
    logic [5:0]  rnd_reg, rnd_next;
    logic [1:0]  oidx_reg, oidx_next;

    logic [2:0]  cnt_sat;
    logic [5:0]  pos_inc;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [3:0]  rd_idx;
    word_t       rd_word;
    chain_t      chain;
    md5_ctl_t    ctl;

    assign cnt_sat = (s_byte_count > MAX_BYTES) ? MAX_BYTES : s_byte_count;
    assign pos_inc = pos_reg + 6'd1;

    always_comb begin
        state_next = state_reg;
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        eom_next   = eom_reg;
        bidx_next  = bidx_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        pad_next   = pad_reg;
        first_next = first_reg;
        tail_next  = tail_reg;
        rnd_next   = rnd_reg;
        oidx_next  = oidx_reg;
        wr_en      = 1'b0;
        wr_byte    = 8'h00;
        ctl        = '0;
        ctl.rnd    = rnd_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    data_next  = s_data_word;
                    cnt_next   = cnt_sat;
                    eom_next   = s_end_of_message;
                    bidx_next  = 3'd0;
                    len_next   = len_reg + {58'd0, cnt_sat, 3'b000};
                    state_next = ST_BYTES;
                end
            end
            ST_BYTES: begin
                if (bidx_reg < cnt_reg) begin
                    wr_en     = 1'b1;
                    wr_byte   = data_reg[{bidx_reg[1:0], 3'b000} +: 8];
                    pos_next  = pos_inc;
                    bidx_next = bidx_reg + 3'd1;
                    if (pos_reg == POS_LAST) begin
                        rnd_next   = 6'd0;
                        state_next = ST_LOAD;
                    end
                end else if (eom_reg) begin
                    pad_next   = 1'b1;
                    first_next = 1'b1;
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                wr_en = 1'b1;
                if (first_reg) begin
                    wr_byte = PAD_MARK;
                end else if (tail_reg) begin
                    // length goes out little-endian in bytes 56..63
                    wr_byte = len_reg[{pos_reg[2:0], 3'b000} +: 8];
                end else begin
                    wr_byte = 8'h00;
                end
                pos_next   = pos_inc;
                first_next = 1'b0;
                if (!tail_reg && pos_inc == POS_LENGTH) begin
                    tail_next = 1'b1;
                end
                if (pos_reg == POS_LAST) begin
                    rnd_next   = 6'd0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ctl.load   = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                ctl.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == POS_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                ctl.finish = 1'b1;
                oidx_next  = 2'd0;
                if (!pad_reg) begin
                    state_next = ST_BYTES;
                end else if (tail_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (oidx_reg == 2'd3) begin
                        // digest taken: fresh message
                        ctl.init   = 1'b1;
                        pos_next   = 6'd0;
                        len_next   = 64'd0;
                        pad_next   = 1'b0;
                        tail_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        oidx_next = oidx_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= 6'd0;
            len_reg   <= 64'd0;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            tail_reg  <= 1'b0;
            bidx_reg  <= 3'd0;
            cnt_reg   <= 3'd0;
            eom_reg   <= 1'b0;
            rnd_reg   <= 6'd0;
            oidx_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            tail_reg  <= tail_next;
            bidx_reg  <= bidx_next;
            cnt_reg   <= cnt_next;
            eom_reg   <= eom_next;
            rnd_reg   <= rnd_next;
            oidx_reg  <= oidx_next;
        end
    end

    // data word needs no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    md5_buf u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_pos  (pos_reg),
        .wr_byte (wr_byte),
        .rd_idx  (rd_idx),
        .rd_word (rd_word)
    );

    md5_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .msg_word (rd_word),
        .msg_idx  (rd_idx),
        .chain    (chain)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_digest_word = chain[oidx_reg];
    assign m_word_index  = oidx_reg;
    assign m_last_word   = (oidx_reg == 2'd3);

endmodule

// ===== hdl/md5_stream_hash_chk.sv =====
// Port-level checker for the MD5 stream hash, bound to the top level.
`include "md5_stream_hash_macros.svh"

module md5_stream_hash_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [1:0]  m_word_index,
    input logic        m_last_word
);

    logic        out_step;      // non-final digest word taken
    logic        out_wait;      // digest word offered but not taken
    logic [1:0]  idx_succ;
    logic [34:0] out_payload;

    assign out_step    = m_valid && m_ready && !m_last_word;
    assign out_wait    = m_valid && !m_ready;
    assign idx_succ    = m_word_index + 2'd1;
    assign out_payload = {m_digest_word, m_word_index, m_last_word};

    // input side is closed while digest words are pending
    `MD5_ASSERT_NEVER(a_no_overlap, aclk, aresetn, s_ready && m_valid)

    `MD5_ASSERT_IMPLY(a_last_is_d, aclk, aresetn, m_valid && m_last_word, m_word_index == 2'd3)

    // an accepted word keeps the block busy in the next cycle
    `MD5_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // digest words follow each other without gaps, in order
    `MD5_ASSERT_NEXT(a_word_order, aclk, aresetn, out_step, m_valid && m_word_index == $past(idx_succ))

    `MD5_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_wait, m_valid && $stable(out_payload))

endmodule

bind md5_stream_hash md5_stream_hash_chk u_chk (.*);

// ===== tb/md5_digest_board_pkg.sv =====
// Scoreboard for the MD5 stream hash: digest predictor and queue of expected digest words.
package md5_digest_board_pkg;

    typedef struct {
        logic [31:0] word;
        logic [1:0]  index;
        logic        is_last;
    } digest_item_t;

    localparam logic [31:0] START_CHAIN [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] ROUND_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_AMOUNT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    localparam int PAD_STOP = 56;

    class digest_board;
        logic [31:0]  chain [4];
        logic [7:0]   blk [64];
        logic [63:0]  bit_len;
        logic [5:0]   fill;
        digest_item_t digest_q [$];
        int           mismatches;

        function new();
            mismatches = 0;
            foreach (blk[i]) blk[i] = 8'h00;
            start_message();
        endfunction

        function void start_message();
            foreach (chain[i]) chain[i] = START_CHAIN[i];
            bit_len = 64'd0;
            fill    = 6'd0;
        endfunction

        // 64 rounds over the full 64-byte block, then fold into the chain
        function void compress_block();
            logic [31:0] a, b, c, d, f, t, m;
            int          g, grp, s;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int r = 0; r < 64; r++) begin
                grp = r / 16;
                case (grp)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = r;
                    end
                    1: begin
                        f = (b & d) | (c & ~d);
                        g = (5 * r + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * r + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * r) % 16;
                    end
                endcase
                m = {blk[4*g+3], blk[4*g+2], blk[4*g+1], blk[4*g]};
                t = a + f + ROUND_ADD[r] + m;
                s = ROT_AMOUNT[grp * 4 + (r % 4)];
                a = d;
                d = c;
                c = b;
                b = b + ((t << s) | (t >> (32 - s)));
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void absorb_byte(logic [7:0] v);
            blk[fill] = v;
            fill = fill + 6'd1;
            if (fill == 6'd0) compress_block();
        endfunction

        // Accepted input word; an end word queues the four digest words.
        function void note_word(logic [31:0] data, logic [2:0] count, logic eom);
            int           n;
            logic [63:0]  len;
            digest_item_t item;
            n = (count > 3'd4) ? 4 : int'(count);
            for (int i = 0; i < n; i++) absorb_byte(data[8*i +: 8]);
            bit_len += 64'(n * 8);
            if (!eom) return;
            len = bit_len;
            absorb_byte(8'h80);
            while (fill != 6'(PAD_STOP)) absorb_byte(8'h00);
            for (int i = 0; i < 8; i++) absorb_byte(len[8*i +: 8]);
            for (int i = 0; i < 4; i++) begin
                item.word    = chain[i];
                item.index   = 2'(i);
                item.is_last = (i == 3);
                digest_q.push_back(item);
            end
            start_message();
        endfunction

        function void check_digest(logic [31:0] word, logic [1:0] index, logic is_last);
            digest_item_t want;
            if (digest_q.size() == 0) begin
                $error("digest word %h arrived with nothing expected", word);
                mismatches++;
                return;
            end
            want = digest_q.pop_front();
            if (word !== want.word) begin
                $error("digest_word expected %h actual %h", want.word, word);
                mismatches++;
            end
            if (index !== want.index) begin
                $error("word_index expected %0d actual %0d", want.index, index);
                mismatches++;
            end
            if (is_last !== want.is_last) begin
                $error("last_word expected %0b actual %0b", want.is_last, is_last);
                mismatches++;
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

endpackage

// ===== tb/tb_md5_stream_hash.sv =====
// Top-level testbench of md5_stream_hash: directed and random messages against a digest scoreboard.
module tb_md5_stream_hash;
    timeunit 1ns;
    timeprecision 1ps;

    import md5_digest_board_pkg::*;

    // Worst case is far below this: all words with their idle gaps and
    // compression shares, plus padding and stalled digest words.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;   // long receiver stall
    localparam int HOLD_AT      = 8;     // digest words seen before the stall
    localparam int DRAIN_CYCLES = 200;   // extra wait after the last digest words
    localparam int RAND_WORDS   = 75;
    localparam int RAND_MSGS    = 10;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data_word;
    logic [2:0]  s_byte_count;
    logic        s_end_of_message;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_digest_word;
    logic [1:0]  m_word_index;
    logic        m_last_word;

    digest_board board = new();
    int          cycles = 0;
    int          words_seen = 0;
    bit          sender_fast = 1'b0;

    md5_stream_hash dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_byte_count     (s_byte_count),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_digest_word    (m_digest_word),
        .m_word_index     (m_word_index),
        .m_last_word      (m_last_word)
    );

    always #2 aclk = ~aclk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one input word after an idle gap; hold it until taken.
    // Valid is only lowered in the gap, so back-to-back words never drop it.
    task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                             input logic eom);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid          <= 1'b1;
        s_data_word      <= data;
        s_byte_count     <= count;
        s_end_of_message <= eom;
        do @(posedge aclk); while (!s_ready);
        board.note_word(data, count, eom);
    endtask

    // Random message: counts 0..7 with random upper-byte garbage.
    // Most are short; every sixth or so is long (14 to 40 words) and may cross block borders.
    task automatic send_message(output int count);
        int n;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 40) : $urandom_range(1, 8);
        sender_fast = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            send_word($urandom(), 3'($urandom_range(0, 7)), i == n - 1);
        end
        count = n;
    endtask

    // Take valid down after the last accepted word, then wait for the digests.
    task automatic wait_for_digests();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // Receiver: random ready gaps per word, a no-stall stretch, and one long
    // hold-off while the sender keeps offering words into a busy block.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (words_seen == HOLD_AT) gap = HOLD_CYCLES;
            else if (words_seen >= 16 && words_seen < 40) gap = 0;
            else gap = $urandom_range(0, 5);
            repeat (gap) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_digest(m_digest_word, m_word_index, m_last_word);
            words_seen++;
        end
    end

    initial begin
        int msgs;
        int sent;
        int n_words;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data_word      = 32'h0;
        s_byte_count     = 3'd0;
        s_end_of_message = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words.
        // Empty message: end word with no bytes and junk in the data.
        send_word(32'hdeadbeef, 3'd0, 1'b1);
        // "abc" with a junk top byte that must be ignored.
        send_word(32'hff636261, 3'd3, 1'b1);
        // Counts 0..2 and 4..7; 5..7 act as 4, count 0 mid-message is a no-op.
        send_word(32'hffffffff, 3'd4, 1'b0);
        send_word(32'h00000000, 3'd0, 1'b0);
        send_word(32'h00000000, 3'd5, 1'b0);
        send_word(32'ha5a5a5a5, 3'd6, 1'b0);
        send_word(32'h5a5a5a5a, 3'd7, 1'b0);
        send_word(32'h12345678, 3'd1, 1'b0);
        send_word(32'hfedcba98, 3'd2, 1'b1);
        // 56 bytes: padding spills into a second block.
        for (int i = 0; i < 14; i++) begin
            send_word((i % 2 == 0) ? 32'hffffffff : 32'h00000000, 3'd4, i == 13);
        end

        // Random messages until enough words and digests have gone through.
        msgs = 0;
        sent = 0;
        while (sent < RAND_WORDS || msgs < RAND_MSGS) begin
            // Sender pause: let the block drain completely once.
            if (msgs == 3) wait_for_digests();
            send_message(n_words);
            msgs++;
            sent += n_words;
        end

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
